// ===== src/lss_pkg.sv =====
// Package: shared types, constants and codes for the line sensor steering block.
`default_nettype none
package lss_pkg;
  localparam int NUM_SENSORS = 6;
  localparam int ADC_W = 10;
  localparam int FULL_SCALE = 1000;
  localparam int NORM_W = 10;
  localparam int POS_W = 13;
  localparam int DRV_W = 9;

  // operation codes
  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_CAL = 3'd1;
  localparam logic [2:0] OP_DISP = 3'd2;
  localparam logic [2:0] OP_START = 3'd3;
  localparam logic [2:0] OP_DRIVE = 3'd4;

  // register indexes
  localparam logic [2:0] REG_BLACK = 3'd0;
  localparam logic [2:0] REG_FWD = 3'd1;
  localparam logic [2:0] REG_PIV = 3'd2;
  localparam logic [2:0] REG_DEAD = 3'd3;
  localparam logic [2:0] REG_THR = 3'd4;
  localparam logic [2:0] REG_NOISE = 3'd5;
  localparam logic [2:0] REG_MINCAL = 3'd6;
  localparam logic [2:0] REG_MEMB = 3'd7;

  typedef struct packed {
    logic        black_reads_low;
    logic [NORM_W-1:0] noise_floor;
    logic [NORM_W-1:0] min_span;
  } lane_cfg_t;
endpackage
`default_nettype wire

// ===== src/lss_lane.sv =====
// Lane: calibration limits of one sensor and a bit-serial scaling divider.
`default_nettype none
module lss_lane #(
  parameter int ADC_BITS = lss_pkg::ADC_W
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire lss_pkg::lane_cfg_t        cfg,
  input  wire logic                      start,
  input  wire logic [2:0]                operation,
  input  wire logic [ADC_BITS-1:0]       raw,
  output logic [lss_pkg::NORM_W-1:0]     value
);
  localparam int NUM_W = ADC_BITS + 10;
  localparam int QW = 11;
  localparam logic [ADC_BITS-1:0] ADC_MAX = {ADC_BITS{1'b1}};

  logic [ADC_BITS-1:0] cal_min, cal_max;
  logic [ADC_BITS-1:0] lo, hi, clamped, span, span_r;
  logic [NUM_W-1:0] num;
  logic [QW-1:0] quo;
  logic [4:0] cnt;
  logic busy, zero_r;
  logic [lss_pkg::NORM_W-1:0] sat;
  logic [ADC_BITS:0] part;
  logic [NUM_W-1:0] dividend;

  // limits seen by this transaction (widened on a calibration sample)
  always_comb begin
    lo = cal_min;
    hi = cal_max;
    if (operation == lss_pkg::OP_CAL) begin
      if (raw < lo) lo = raw;
      if (raw > hi) hi = raw;
    end
    clamped = raw;
    if (clamped < lo) clamped = lo;
    if (clamped > hi) clamped = hi;
    span = hi - lo;
    if (cfg.black_reads_low) num = NUM_W'(hi - clamped) * NUM_W'(lss_pkg::FULL_SCALE);
    else num = NUM_W'(clamped - lo) * NUM_W'(lss_pkg::FULL_SCALE);
  end

  // calibration store
  always_ff @(posedge clk) begin
    if (rst || (start && operation == lss_pkg::OP_CLEAR)) begin
      cal_min <= ADC_MAX;
      cal_max <= '0;
    end else if (start && operation == lss_pkg::OP_CAL) begin
      cal_min <= lo;
      cal_max <= hi;
    end
  end

  // divider control, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= 5'(NUM_W);
      span_r <= span;
      zero_r <= (hi <= lo) || (NUM_W'(span) < NUM_W'(cfg.min_span));
    end else if (busy) begin
      if (cnt == 5'd0) busy <= 1'b0;
      else cnt <= cnt - 5'd1;
    end
  end

  // long division: shift-subtract on the partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      part <= '0;
      dividend <= num;
      quo <= '0;
    end else if (busy && cnt != 5'd0) begin
      if ({part[ADC_BITS-1:0], dividend[NUM_W-1]} >= {1'b0, span_r}) begin
        part <= {part[ADC_BITS-1:0], dividend[NUM_W-1]} - {1'b0, span_r};
        quo <= {quo[QW-2:0], 1'b1};
      end else begin
        part <= {part[ADC_BITS-1:0], dividend[NUM_W-1]};
        quo <= {quo[QW-2:0], 1'b0};
      end
      dividend <= {dividend[NUM_W-2:0], 1'b0};
    end
  end

  always_comb begin
    if (quo > QW'(lss_pkg::FULL_SCALE)) sat = lss_pkg::NORM_W'(lss_pkg::FULL_SCALE);
    else sat = quo[lss_pkg::NORM_W-1:0];
    if (zero_r || sat < cfg.noise_floor) value = '0;
    else value = sat;
  end
endmodule
`default_nettype wire

// ===== src/lss_merge.sv =====
// Merge: detect mask, weighted sum, position divide and steering.
`default_nettype none
module lss_merge (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  input  wire logic [2:0]                            operation,
  input  wire logic [lss_pkg::NUM_SENSORS*lss_pkg::NORM_W-1:0] values,
  input  wire logic [lss_pkg::NORM_W-1:0]            detect_threshold,
  input  wire logic [7:0]                            fwd_speed,
  input  wire logic [7:0]                            turn_speed,
  input  wire logic [11:0]                           dead_band,
  input  wire logic [11:0]                           memory_band,
  output logic                                       done,
  output logic [lss_pkg::NUM_SENSORS-1:0]            detect_mask,
  output logic                                       line_seen,
  output logic signed [lss_pkg::POS_W-1:0]           line_position,
  output logic signed [lss_pkg::DRV_W-1:0]           left_drive,
  output logic signed [lss_pkg::DRV_W-1:0]           right_drive,
  output logic signed [1:0]                          heading_out
);
  localparam int NS = lss_pkg::NUM_SENSORS;
  localparam int TW = lss_pkg::NORM_W + $clog2(NS) + 1;
  localparam int WW = TW + 14;
  localparam int IW = $clog2(NS + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_SUM = 4'b0010, S_DIV = 4'b0100, S_FIN = 4'b1000
  } state_t;
  state_t state;

  logic [2:0] op_r;
  logic [IW-1:0] idx;
  logic [TW-1:0] total;
  logic [lss_pkg::NORM_W-1:0] strongest;
  logic signed [WW-1:0] wsum;
  logic [WW-1:0] dmag, quo, part;
  logic [6:0] dcnt;
  logic neg;
  logic signed [1:0] heading;
  logic [lss_pkg::NORM_W-1:0] cur;
  logic signed [15:0] weight;
  logic signed [WW:0] q_s;
  logic signed [lss_pkg::POS_W-1:0] pos;
  logic fnd;
  logic [WW:0] sub;
  logic [NS-1:0] mask_next;
  logic found_next;
  logic signed [lss_pkg::POS_W-1:0] pos_next;
  logic signed [lss_pkg::DRV_W-1:0] left_next, right_next;
  logic signed [1:0] heading_next;

  assign cur = values[idx*lss_pkg::NORM_W +: lss_pkg::NORM_W];
  assign weight = 16'(int'(idx) * 1000 - 500 * (NS - 1));
  assign fnd = (strongest >= detect_threshold) && (total != '0);
  assign sub = {part, dmag[WW-1]} - {1'b0, (WW)'(total)};
  assign q_s = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

  always_comb begin
    if (q_s > (WW+1)'(4095)) pos = 13'sd4095;
    else if (q_s < -(WW+1)'(4096)) pos = -13'sd4096;
    else pos = q_s[lss_pkg::POS_W-1:0];
  end

  // result fields and heading for the finished transaction
  always_comb begin
    mask_next = '0;
    found_next = 1'b0;
    pos_next = '0;
    left_next = '0;
    right_next = '0;
    heading_next = heading;
    if (op_r == lss_pkg::OP_CAL || op_r == lss_pkg::OP_DISP ||
        op_r == lss_pkg::OP_DRIVE) begin
      mask_next = detect_mask;
      found_next = fnd;
      pos_next = fnd ? pos : '0;
    end
    if (op_r == lss_pkg::OP_START) heading_next = '0;
    if (op_r == lss_pkg::OP_DRIVE) begin
      if (fnd) begin
        if (pos < -$signed({1'b0, dead_band})) begin
          heading_next = -2'sd1;
          left_next = -$signed({1'b0, turn_speed});
          right_next = $signed({1'b0, turn_speed});
        end else if (pos > $signed({1'b0, dead_band})) begin
          heading_next = 2'sd1;
          left_next = $signed({1'b0, turn_speed});
          right_next = -$signed({1'b0, turn_speed});
        end else begin
          if (pos < -$signed({1'b0, memory_band})) heading_next = -2'sd1;
          else if (pos > $signed({1'b0, memory_band})) heading_next = 2'sd1;
          left_next = $signed({1'b0, fwd_speed});
          right_next = $signed({1'b0, fwd_speed});
        end
      end else if (heading < 0) begin
        left_next = -$signed({1'b0, turn_speed});
        right_next = $signed({1'b0, turn_speed});
      end else if (heading > 0) begin
        left_next = $signed({1'b0, turn_speed});
        right_next = -$signed({1'b0, turn_speed});
      end
    end
  end

  // one lane a cycle into the sums, then a bit-serial divide
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      heading <= '0;
      done <= 1'b0;
    end else begin
      done <= (state == S_FIN);
      unique case (state)
        S_IDLE: if (start) begin
          op_r <= operation;
          idx <= '0;
          total <= '0;
          strongest <= '0;
          wsum <= '0;
          detect_mask <= '0;
          state <= S_SUM;
        end
        S_SUM: begin
          if (cur >= detect_threshold) detect_mask[idx[$clog2(NS)-1:0]] <= 1'b1;
          if (cur > strongest) strongest <= cur;
          total <= total + TW'(cur);
          wsum <= wsum + WW'($signed({1'b0, cur}) * weight);
          if (idx == IW'(NS - 1)) state <= S_DIV;
          idx <= idx + IW'(1);
          neg <= 1'b0;
          dcnt <= 7'(WW);
        end
        S_DIV: begin
          if (dcnt == 7'(WW)) begin
            neg <= wsum < 0;
            dmag <= wsum < 0 ? WW'(-wsum) : WW'(wsum);
            part <= '0;
            quo <= '0;
            dcnt <= dcnt - 7'd1;
          end else begin
            if (!sub[WW]) begin
              part <= sub[WW-1:0];
              quo <= {quo[WW-2:0], 1'b1};
            end else begin
              part <= {part[WW-2:0], dmag[WW-1]};
              quo <= {quo[WW-2:0], 1'b0};
            end
            dmag <= {dmag[WW-2:0], 1'b0};
            if (dcnt == 7'd0) state <= S_FIN;
            dcnt <= dcnt - 7'd1;
          end
        end
        S_FIN: begin
          state <= S_IDLE;
          detect_mask <= mask_next;
          line_seen <= found_next;
          line_position <= pos_next;
          left_drive <= left_next;
          right_drive <= right_next;
          heading <= heading_next;
          heading_out <= heading_next;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== src/line_sensor_steering.sv =====
// Top level: six sensor lanes, merge stage, APB registers and output register.
//
//  channel | signals                        | direction
//  in      | in_valid/in_ready, operation, raw_0..raw_5 | to block
//  out     | out_valid/out_ready, result fields          | from block
//  cfg     | APB psel..prdata                            | to block
//
// One transaction at a time: after the input is taken, the lane dividers run and hand
// off, the merge stage sums the lanes one by one, the serial position divider runs, and
// the result is registered before out_valid rises.
// Synchronous reset restores registers, calibration limits and heading.
// A finished result waits in the output register; the next transaction is
// taken once the previous result is taken.
`default_nettype none
module line_sensor_steering #(
  parameter int ADC_BITS = lss_pkg::ADC_W
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [2:0]          operation,
  input  wire logic [ADC_BITS-1:0] raw_0,
  input  wire logic [ADC_BITS-1:0] raw_1,
  input  wire logic [ADC_BITS-1:0] raw_2,
  input  wire logic [ADC_BITS-1:0] raw_3,
  input  wire logic [ADC_BITS-1:0] raw_4,
  input  wire logic [ADC_BITS-1:0] raw_5,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [5:0]               detect_mask,
  output logic                     line_seen,
  output logic signed [12:0]       line_position,
  output logic signed [8:0]        left_drive,
  output logic signed [8:0]        right_drive,
  output logic signed [1:0]        heading_out,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [4:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  localparam int NS = lss_pkg::NUM_SENSORS;
  localparam int NW = lss_pkg::NORM_W;

  logic black_reads_low;
  logic [7:0] fwd_speed, turn_speed;
  logic [11:0] dead_band, memory_band;
  logic [9:0] detect_threshold, noise_floor, min_span;
  logic busy, start, done;
  logic [2:0] op_r;
  logic [NS*ADC_BITS-1:0] raws;
  logic [NS*NW-1:0] values;
  logic [5:0] m_mask;
  logic m_found;
  logic signed [12:0] m_pos;
  logic signed [8:0] m_left, m_right;
  logic signed [1:0] m_head;
  logic [4:0] wait_cnt;
  lss_pkg::lane_cfg_t lcfg;

  assign pready = 1'b1;
  assign lcfg = '{black_reads_low, noise_floor, min_span};

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      black_reads_low <= 1'b1;
      fwd_speed <= 8'd150;
      turn_speed <= 8'd140;
      dead_band <= 12'd700;
      detect_threshold <= 10'd300;
      noise_floor <= 10'd40;
      min_span <= 10'd40;
      memory_band <= 12'd100;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        lss_pkg::REG_BLACK:  black_reads_low <= pwdata[0];
        lss_pkg::REG_FWD:    fwd_speed <= pwdata[7:0];
        lss_pkg::REG_PIV:    turn_speed <= pwdata[7:0];
        lss_pkg::REG_DEAD:   dead_band <= pwdata[11:0];
        lss_pkg::REG_THR:    detect_threshold <= pwdata[9:0];
        lss_pkg::REG_NOISE:  noise_floor <= pwdata[9:0];
        lss_pkg::REG_MINCAL: min_span <= pwdata[9:0];
        lss_pkg::REG_MEMB:   memory_band <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      lss_pkg::REG_BLACK:  prdata = 32'(black_reads_low);
      lss_pkg::REG_FWD:    prdata = 32'(fwd_speed);
      lss_pkg::REG_PIV:    prdata = 32'(turn_speed);
      lss_pkg::REG_DEAD:   prdata = 32'(dead_band);
      lss_pkg::REG_THR:    prdata = 32'(detect_threshold);
      lss_pkg::REG_NOISE:  prdata = 32'(noise_floor);
      lss_pkg::REG_MINCAL: prdata = 32'(min_span);
      lss_pkg::REG_MEMB:   prdata = 32'(memory_band);
      default:             prdata = '0;
    endcase
  end

  // transaction control: lanes start on accept, merge after lane dividers
  assign in_ready = !busy && !out_valid;
  assign start = in_valid && in_ready;
  assign raws = {raw_5, raw_4, raw_3, raw_2, raw_1, raw_0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      out_valid <= 1'b0;
      wait_cnt <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        op_r <= operation;
        wait_cnt <= 5'(ADC_BITS + 12);
      end else if (wait_cnt != '0) wait_cnt <= wait_cnt - 5'd1;
      if (done) begin
        busy <= 1'b0;
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  logic m_start;
  assign m_start = busy && wait_cnt == 5'd1;

  genvar g;
  generate
    for (g = 0; g < NS; g++) begin : g_lane
      lss_lane #(.ADC_BITS(ADC_BITS)) u_lane (
        .clk(clk), .rst(rst), .cfg(lcfg), .start(start), .operation(operation),
        .raw(raws[g*ADC_BITS +: ADC_BITS]),
        .value(values[g*NW +: NW])
      );
    end
  endgenerate

  lss_merge u_merge (
    .clk(clk), .rst(rst), .start(m_start), .operation(op_r), .values(values),
    .detect_threshold(detect_threshold), .fwd_speed(fwd_speed),
    .turn_speed(turn_speed), .dead_band(dead_band),
    .memory_band(memory_band), .done(done), .detect_mask(m_mask),
    .line_seen(m_found), .line_position(m_pos), .left_drive(m_left),
    .right_drive(m_right), .heading_out(m_head)
  );

  // result fields come straight from the merge stage's held registers
  assign detect_mask = m_mask;
  assign line_seen = m_found;
  assign line_position = m_pos;
  assign left_drive = m_left;
  assign right_drive = m_right;
  assign heading_out = m_head;

  logic unused;
  assign unused = ^{paddr[1:0], pwdata[31:12]};
endmodule
`default_nettype wire
